// ----- design/vsam_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vsam_pkg
// Shared types, register indexes, reset values and fixed-point constants of
// the vital sign alarm monitor.
// ----------------------------------------------------------------------------
package vsam_pkg;

	// Field widths
	localparam int TEMP_W     = 12;
	localparam int PRESS_W    = 9;
	localparam int RAW_W      = 8;
	localparam int RATE_W     = 8;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	// Default block parameters
	localparam int BUZZER_DIVIDE_DEF    = 9;
	localparam int AVERAGE_SAMPLES_DEF  = 8;
	localparam int TICKS_PER_SECOND_DEF = 100;
	localparam int WINDOW_SECONDS_DEF   = 5;

	// Pressure scaling raw*500/255 as a multiply by a rounded-up reciprocal;
	// exact floor for every 8-bit sample
	localparam int PRESS_FULL   = 500;
	localparam int PRESS_DIV    = 255;
	localparam int PRESS_SHIFT  = 16;
	localparam int PRESS_MULT   = (PRESS_FULL * (2 ** PRESS_SHIFT) + PRESS_DIV - 1) / PRESS_DIV;
	localparam int PRESS_MULT_W = $clog2(PRESS_MULT + 1);
	localparam int PRESS_PROD_W = RAW_W + PRESS_MULT_W;

	// Item kinds
	typedef enum logic [MODE_W-1:0] {
		MODE_SAMPLE = 2'd0,
		MODE_EDGE   = 2'd1,
		MODE_TICK   = 2'd2
	} mode_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP_HIGH = 3'd0,
		REG_TEMP_LOW  = 3'd1,
		REG_DIA_HIGH  = 3'd2,
		REG_DIA_LOW   = 3'd3,
		REG_SYS_HIGH  = 3'd4,
		REG_SYS_LOW   = 3'd5,
		REG_PULSE_HIGH = 3'd6,
		REG_PULSE_LOW = 3'd7
	} cfg_idx_t;

	// Limit reset values
	localparam logic signed [TEMP_W-1:0] TEMP_HIGH_RST = 12'sd372;
	localparam logic signed [TEMP_W-1:0] TEMP_LOW_RST  = 12'sd365;
	localparam logic [PRESS_W-1:0] DIA_HIGH_RST   = 9'd90;
	localparam logic [PRESS_W-1:0] DIA_LOW_RST    = 9'd60;
	localparam logic [PRESS_W-1:0] SYS_HIGH_RST   = 9'd140;
	localparam logic [PRESS_W-1:0] SYS_LOW_RST    = 9'd90;
	localparam logic [RATE_W-1:0]  PULSE_HIGH_RST = 8'd100;
	localparam logic [RATE_W-1:0]  PULSE_LOW_RST  = 8'd60;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp_high;
		logic signed [TEMP_W-1:0] temp_low;
		logic [PRESS_W-1:0]       dia_high;
		logic [PRESS_W-1:0]       dia_low;
		logic [PRESS_W-1:0]       sys_high;
		logic [PRESS_W-1:0]       sys_low;
		logic [RATE_W-1:0]        pulse_high;
		logic [RATE_W-1:0]        pulse_low;
	} limits_t;

	// Input item after unit conversion
	typedef struct packed {
		mode_t                    mode;
		logic                     temp_valid;
		logic signed [TEMP_W-1:0] temp_tenths;
		logic [PRESS_W-1:0]       dia_scaled;
		logic [PRESS_W-1:0]       sys_scaled;
	} item_t;

	typedef struct packed {
		logic                     alarm;
		logic                     buzzer;
		logic signed [TEMP_W-1:0] temp_tenths;
		logic [PRESS_W-1:0]       dia_avg;
		logic [PRESS_W-1:0]       sys_avg;
		logic [RATE_W-1:0]        pulse_rate;
	} result_t;

endpackage
`default_nettype wire

// ----- design/vsam_cfg_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vsam_cfg_regs
// Limit register file; one indexed write per cycle, fields truncated to
// their own widths.
// ----------------------------------------------------------------------------
module vsam_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [vsam_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [vsam_pkg::CFG_DATA_W-1:0] wr_data,
	output vsam_pkg::limits_t                   limits
);
	import vsam_pkg::*;

	limits_t limits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.temp_high  <= TEMP_HIGH_RST;
			limits_q.temp_low   <= TEMP_LOW_RST;
			limits_q.dia_high   <= DIA_HIGH_RST;
			limits_q.dia_low    <= DIA_LOW_RST;
			limits_q.sys_high   <= SYS_HIGH_RST;
			limits_q.sys_low    <= SYS_LOW_RST;
			limits_q.pulse_high <= PULSE_HIGH_RST;
			limits_q.pulse_low  <= PULSE_LOW_RST;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				REG_TEMP_HIGH:  limits_q.temp_high  <= wr_data[TEMP_W-1:0];
				REG_TEMP_LOW:   limits_q.temp_low   <= wr_data[TEMP_W-1:0];
				REG_DIA_HIGH:   limits_q.dia_high   <= wr_data[PRESS_W-1:0];
				REG_DIA_LOW:    limits_q.dia_low    <= wr_data[PRESS_W-1:0];
				REG_SYS_HIGH:   limits_q.sys_high   <= wr_data[PRESS_W-1:0];
				REG_SYS_LOW:    limits_q.sys_low    <= wr_data[PRESS_W-1:0];
				REG_PULSE_HIGH: limits_q.pulse_high <= wr_data[RATE_W-1:0];
				REG_PULSE_LOW:  limits_q.pulse_low  <= wr_data[RATE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign limits = limits_q;

endmodule
`default_nettype wire

// ----- design/vsam_update.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vsam_update
// Monitor state and its update logic: pressure averaging, pulse
// window, limit checks and buzzer divider.
// ----------------------------------------------------------------------------
module vsam_update #(
	parameter int BUZZER_DIVIDE    = vsam_pkg::BUZZER_DIVIDE_DEF,
	parameter int AVERAGE_SAMPLES  = vsam_pkg::AVERAGE_SAMPLES_DEF,
	parameter int TICKS_PER_SECOND = vsam_pkg::TICKS_PER_SECOND_DEF,
	parameter int WINDOW_SECONDS   = vsam_pkg::WINDOW_SECONDS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               advance,
	input  wire vsam_pkg::item_t    item,
	input  wire vsam_pkg::limits_t  limits,
	output vsam_pkg::result_t       result_next
);
	import vsam_pkg::*;

	localparam int CNT_W   = $clog2(AVERAGE_SAMPLES);
	localparam int SUM_W   = $clog2(PRESS_FULL * AVERAGE_SAMPLES + 1);
	localparam int AVG_SHIFT = SUM_W + $clog2(AVERAGE_SAMPLES);
	localparam int AVG_MULT  = (2 ** AVG_SHIFT + AVERAGE_SAMPLES - 1) / AVERAGE_SAMPLES;
	localparam int AVG_MULT_W = $clog2(AVG_MULT + 1);
	localparam int AVG_PROD_W = SUM_W + AVG_MULT_W;
	localparam int TICK_W  = $clog2(TICKS_PER_SECOND + 1);
	localparam int SEC_W   = $clog2(WINDOW_SECONDS + 1);
	localparam int PH_W    = $clog2(BUZZER_DIVIDE);

	logic [SUM_W-1:0]         dia_sum_q, dia_sum_d, sys_sum_q, sys_sum_d;
	logic [CNT_W-1:0]         smp_cnt_q, smp_cnt_d;
	logic [PRESS_W-1:0]       dia_hold_q, dia_hold_d, sys_hold_q, sys_hold_d;
	logic signed [TEMP_W-1:0] temp_hold_q, temp_hold_d;
	logic [RATE_W-1:0]        edge_cnt_q, edge_cnt_d, rate_hold_q, rate_hold_d;
	logic [TICK_W-1:0]        tick_cnt_q, tick_cnt_d, tick_inc;
	logic [SEC_W-1:0]         sec_cnt_q, sec_cnt_d, sec_inc;
	logic                     rate_pend_q, rate_pend_d;
	logic                     alarm_q, alarm_d;
	logic [PH_W-1:0]          buzz_ph_q, buzz_ph_d, ph_inc;
	logic                     buzz_pin_q, buzz_pin_d;

	logic [SUM_W-1:0]      dia_sum_add, sys_sum_add;
	logic [AVG_PROD_W-1:0] dia_prod, sys_prod;
	logic [PRESS_W-1:0]    dia_avg, sys_avg;
	logic                  avg_done;
	logic                  temp_alarm, press_alarm, pulse_alarm;
	logic [RATE_W-1:0]     window_rate;

	// Running sums including the current sample
	assign dia_sum_add = dia_sum_q + SUM_W'(item.dia_scaled);
	assign sys_sum_add = sys_sum_q + SUM_W'(item.sys_scaled);
	assign avg_done    = ({1'b0, smp_cnt_q} + 1'b1) == (CNT_W + 1)'(AVERAGE_SAMPLES);

	// Divide by the sample count through a rounded-up reciprocal
	assign dia_prod = AVG_PROD_W'(dia_sum_add) * AVG_PROD_W'(AVG_MULT);
	assign sys_prod = AVG_PROD_W'(sys_sum_add) * AVG_PROD_W'(AVG_MULT);
	assign dia_avg  = PRESS_W'(dia_prod >> AVG_SHIFT);
	assign sys_avg  = PRESS_W'(sys_prod >> AVG_SHIFT);

	assign temp_alarm  = ($signed(item.temp_tenths) > $signed(limits.temp_high)) ||
	                     ($signed(item.temp_tenths) < $signed(limits.temp_low));
	assign press_alarm = (dia_avg > limits.dia_high) || (dia_avg < limits.dia_low) ||
	                     (sys_avg > limits.sys_high) || (sys_avg < limits.sys_low);
	assign pulse_alarm = (rate_hold_q > limits.pulse_high) ||
	                     (rate_hold_q < limits.pulse_low);

	// Edges times twelve, wrapped to eight bits
	assign window_rate = {edge_cnt_q[RATE_W-4:0], 3'b000} + {edge_cnt_q[RATE_W-3:0], 2'b00};

	assign tick_inc = tick_cnt_q + 1'b1;
	assign sec_inc  = sec_cnt_q + 1'b1;
	// Buzzer count modulo the divider; its wrap keeps the same residue
	assign ph_inc   = (buzz_ph_q == PH_W'(BUZZER_DIVIDE - 1)) ? '0 : buzz_ph_q + 1'b1;

	always_comb begin
		dia_sum_d   = dia_sum_q;
		sys_sum_d   = sys_sum_q;
		smp_cnt_d   = smp_cnt_q;
		dia_hold_d  = dia_hold_q;
		sys_hold_d  = sys_hold_q;
		temp_hold_d = temp_hold_q;
		edge_cnt_d  = edge_cnt_q;
		tick_cnt_d  = tick_cnt_q;
		sec_cnt_d   = sec_cnt_q;
		rate_hold_d = rate_hold_q;
		rate_pend_d = rate_pend_q;
		alarm_d     = alarm_q;
		buzz_ph_d   = buzz_ph_q;
		buzz_pin_d  = buzz_pin_q;
		case (item.mode)
			MODE_SAMPLE: begin
				if (item.temp_valid) begin
					temp_hold_d = item.temp_tenths;
					alarm_d     = temp_alarm;
				end
				if (avg_done) begin
					dia_hold_d = dia_avg;
					sys_hold_d = sys_avg;
					dia_sum_d  = '0;
					sys_sum_d  = '0;
					smp_cnt_d  = '0;
					alarm_d    = press_alarm;
				end else begin
					dia_sum_d = dia_sum_add;
					sys_sum_d = sys_sum_add;
					smp_cnt_d = smp_cnt_q + 1'b1;
				end
				if (rate_pend_q) begin
					rate_pend_d = 1'b0;
					alarm_d     = pulse_alarm;
				end
				buzz_ph_d = ph_inc;
				if ((ph_inc == '0) && alarm_d) begin
					buzz_pin_d = !buzz_pin_q;
				end
			end
			MODE_EDGE: begin
				edge_cnt_d = edge_cnt_q + 1'b1;
			end
			MODE_TICK: begin
				if (tick_inc == TICK_W'(TICKS_PER_SECOND)) begin
					tick_cnt_d = '0;
					if (sec_inc == SEC_W'(WINDOW_SECONDS)) begin
						sec_cnt_d   = '0;
						rate_hold_d = window_rate;
						edge_cnt_d  = '0;
						rate_pend_d = 1'b1;
					end else begin
						sec_cnt_d = sec_inc;
					end
				end else begin
					tick_cnt_d = tick_inc;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dia_sum_q   <= '0;
			sys_sum_q   <= '0;
			smp_cnt_q   <= '0;
			dia_hold_q  <= '0;
			sys_hold_q  <= '0;
			temp_hold_q <= '0;
			edge_cnt_q  <= '0;
			tick_cnt_q  <= '0;
			sec_cnt_q   <= '0;
			rate_hold_q <= '0;
			rate_pend_q <= 1'b0;
			alarm_q     <= 1'b0;
			buzz_ph_q   <= '0;
			buzz_pin_q  <= 1'b0;
		end else if (advance) begin
			dia_sum_q   <= dia_sum_d;
			sys_sum_q   <= sys_sum_d;
			smp_cnt_q   <= smp_cnt_d;
			dia_hold_q  <= dia_hold_d;
			sys_hold_q  <= sys_hold_d;
			temp_hold_q <= temp_hold_d;
			edge_cnt_q  <= edge_cnt_d;
			tick_cnt_q  <= tick_cnt_d;
			sec_cnt_q   <= sec_cnt_d;
			rate_hold_q <= rate_hold_d;
			rate_pend_q <= rate_pend_d;
			alarm_q     <= alarm_d;
			buzz_ph_q   <= buzz_ph_d;
			buzz_pin_q  <= buzz_pin_d;
		end
	end

	assign result_next.alarm       = alarm_d;
	assign result_next.buzzer      = buzz_pin_d;
	assign result_next.temp_tenths = temp_hold_d;
	assign result_next.dia_avg     = dia_hold_d;
	assign result_next.sys_avg     = sys_hold_d;
	assign result_next.pulse_rate  = rate_hold_d;

endmodule
`default_nettype wire

// ----- design/vital_sign_alarm_monitor_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vital_sign_alarm_monitor_core
// Vital sign alarm monitor: temperature, averaged blood pressure and pulse
// rate checked against programmable limits, with a divided alarm buzzer.
// ----------------------------------------------------------------------------
// The monitor takes one item per clock and returns one result for every item
// it takes. An item is a sample (optional temperature in 1/16 degree plus
// one diastolic and one systolic 8-bit converter sample), a pulse edge, or a
// 10 ms tick; mode code 3 changes nothing and repeats the held values. Each
// result carries the alarm, the buzzer pin level and the held temperature in
// tenths, pressure averages and pulse rate, all as they stand after the item.
// An item is converted to tenths and scaled pressure on its way into the
// input register; the whole state update then runs in the single stage
// between the input register and the result register, so the result of an
// item is registered there when it advances, and a new item can follow every
// cycle unless stalled. The input side stalls only while the input register
// holds an item and the result register holds a result that the sink is
// stalling. Limits are written through the configuration port, which is
// always ready; write them only while no item is in flight.
// ----------------------------------------------------------------------------
module vital_sign_alarm_monitor_core #(
	parameter int BUZZER_DIVIDE    = vsam_pkg::BUZZER_DIVIDE_DEF,
	parameter int AVERAGE_SAMPLES  = vsam_pkg::AVERAGE_SAMPLES_DEF,
	parameter int TICKS_PER_SECOND = vsam_pkg::TICKS_PER_SECOND_DEF,
	parameter int WINDOW_SECONDS   = vsam_pkg::WINDOW_SECONDS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// Input item channel
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [vsam_pkg::MODE_W-1:0]           mode,
	input  wire logic                                  temp_valid,
	input  wire logic signed [vsam_pkg::TEMP_W-1:0]    temp_raw,
	input  wire logic [vsam_pkg::RAW_W-1:0]            diastolic_raw,
	input  wire logic [vsam_pkg::RAW_W-1:0]            systolic_raw,
	// Result channel
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic                                       alarm,
	output logic                                       buzzer_level,
	output logic signed [vsam_pkg::TEMP_W-1:0]         temperature_tenths,
	output logic [vsam_pkg::PRESS_W-1:0]               diastolic_avg,
	output logic [vsam_pkg::PRESS_W-1:0]               systolic_avg,
	output logic [vsam_pkg::RATE_W-1:0]                pulse_rate,
	// Configuration write channel
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [vsam_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [vsam_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import vsam_pkg::*;

	logic                      valid_s1;
	item_t                     item_s1;
	item_t                     item_in;
	logic                      advance;
	limits_t                   limits;
	result_t                   result_next;
	result_t                   result_q;
	logic                      out_valid_q;

	logic signed [TEMP_W+3:0]  temp_ext;
	logic signed [TEMP_W+3:0]  temp_x10;
	logic [PRESS_PROD_W-1:0]   dia_prod;
	logic [PRESS_PROD_W-1:0]   sys_prod;

	// Configuration: limits are taken on every valid write
	assign cfg_ready = 1'b1;

	vsam_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.limits   (limits)
	);

	// Convert units ahead of the input register: tenths are floor(raw*10/16),
	// which is the arithmetic shift of raw*10 by four
	assign temp_ext = {{4{temp_raw[TEMP_W-1]}}, temp_raw};
	assign temp_x10 = (temp_ext <<< 3) + (temp_ext <<< 1);

	// Scale pressures by 500/255 with a reciprocal multiply
	assign dia_prod = PRESS_PROD_W'(diastolic_raw) * PRESS_PROD_W'(PRESS_MULT);
	assign sys_prod = PRESS_PROD_W'(systolic_raw) * PRESS_PROD_W'(PRESS_MULT);

	assign item_in.mode        = mode_t'(mode);
	assign item_in.temp_valid  = temp_valid;
	assign item_in.temp_tenths = temp_x10[TEMP_W+3:4];
	assign item_in.dia_scaled  = dia_prod[PRESS_SHIFT +: PRESS_W];
	assign item_in.sys_scaled  = sys_prod[PRESS_SHIFT +: PRESS_W];

	// Advance the held item whenever the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold the item payload until the next transfer
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= item_in;
		end
	end

	vsam_update #(
		.BUZZER_DIVIDE    (BUZZER_DIVIDE),
		.AVERAGE_SAMPLES  (AVERAGE_SAMPLES),
		.TICKS_PER_SECOND (TICKS_PER_SECOND),
		.WINDOW_SECONDS   (WINDOW_SECONDS)
	) u_update (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.item        (item_s1),
		.limits      (limits),
		.result_next (result_next)
	);

	// Result register: load on advance, drop the valid once the sink takes it.
	// The payload resets to the state's reset values so it always mirrors
	// the last result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			result_q    <= '0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
			result_q    <= result_next;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid          = out_valid_q;
	assign alarm              = result_q.alarm;
	assign buzzer_level       = result_q.buzzer;
	assign temperature_tenths = result_q.temp_tenths;
	assign diastolic_avg      = result_q.dia_avg;
	assign systolic_avg       = result_q.sys_avg;
	assign pulse_rate         = result_q.pulse_rate;

	// Input side stalls only behind a held item and a stalled full result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	// Pulse edges and unused codes leave every reported value unchanged
	a_edge_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.mode != MODE_SAMPLE && item_s1.mode != MODE_TICK)
		|=> (result_q == $past(result_q)))
		else $error("non-sample, non-tick item changed the result");

	// The buzzer toggles only while the alarm is set
	a_buzzer_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (buzzer_level == $past(buzzer_level)) || alarm)
		else $error("buzzer toggled with alarm clear");

endmodule
`default_nettype wire

// ----- sim/vital_sign_alarm_monitor_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vital_sign_alarm_monitor_core_tb
// Self-checking bench for the vital sign alarm monitor. A scoreboard object
// keeps its own copy of the limits and of the averaging, pulse window, alarm
// and buzzer state, predicts one reading per accepted item and compares every
// transferred result with the oldest prediction. Stimulus is a short directed
// opening followed by random segments with varied item mixes and limit sets.
// ----------------------------------------------------------------------------
module vital_sign_alarm_monitor_core_tb;
	import vsam_pkg::*;

	// Mode code three has no member in the package enum; the block holds state
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	// Rate in beats per minute per edge counted over one window
	localparam int BEATS_PER_EDGE = 60 / WINDOW_SECONDS_DEF;

	// One item as driven onto the input channel, before unit conversion
	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic                     temp_valid;
		logic signed [TEMP_W-1:0] temp_raw;
		logic [RAW_W-1:0]         dia_raw;
		logic [RAW_W-1:0]         sys_raw;
	} reading_t;

	// ------------------------------------------------------------------------
	// Scoreboard: predicts the monitor outputs and checks transferred results
	// ------------------------------------------------------------------------
	class vital_check_board;
		// Limits as last written
		int temp_hi, temp_lo, dia_hi, dia_lo, sys_hi, sys_lo, pulse_hi, pulse_lo;
		// Monitor state
		int dia_sum, sys_sum, sample_cnt, dia_hold, sys_hold, temp_hold;
		int edge_cnt, tick_cnt, sec_cnt, rate_hold, buzz_cnt;
		bit rate_pending, alarm_on, buzz_pin;
		int mismatches;
		result_t expected_readings[$];

		function new();
			temp_hi  = int'(TEMP_HIGH_RST);
			temp_lo  = int'(TEMP_LOW_RST);
			dia_hi   = int'(DIA_HIGH_RST);
			dia_lo   = int'(DIA_LOW_RST);
			sys_hi   = int'(SYS_HIGH_RST);
			sys_lo   = int'(SYS_LOW_RST);
			pulse_hi = int'(PULSE_HIGH_RST);
			pulse_lo = int'(PULSE_LOW_RST);
		endfunction

		function void set_limit(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_TEMP_HIGH:  temp_hi  = int'($signed(data));
			REG_TEMP_LOW:   temp_lo  = int'($signed(data));
			REG_DIA_HIGH:   dia_hi   = int'(data[PRESS_W-1:0]);
			REG_DIA_LOW:    dia_lo   = int'(data[PRESS_W-1:0]);
			REG_SYS_HIGH:   sys_hi   = int'(data[PRESS_W-1:0]);
			REG_SYS_LOW:    sys_lo   = int'(data[PRESS_W-1:0]);
			REG_PULSE_HIGH: pulse_hi = int'(data[RATE_W-1:0]);
			REG_PULSE_LOW:  pulse_lo = int'(data[RATE_W-1:0]);
			default: ;
			endcase
		endfunction

		// Advance the monitor state by one accepted item and queue its reading
		function void note_item(reading_t it);
			int tenths;
			result_t want;
			case (it.mode)
			MODE_SAMPLE: begin
				// Temperature check comes first; floor of raw*10/16
				if (it.temp_valid) begin
					tenths = int'($signed(it.temp_raw)) * 10;
					tenths = tenths >>> 4;
					temp_hold = tenths;
					alarm_on = (tenths > temp_hi) || (tenths < temp_lo);
				end
				dia_sum += int'(it.dia_raw) * PRESS_FULL / PRESS_DIV;
				sys_sum += int'(it.sys_raw) * PRESS_FULL / PRESS_DIV;
				sample_cnt++;
				if (sample_cnt >= AVERAGE_SAMPLES_DEF) begin
					dia_hold = dia_sum / AVERAGE_SAMPLES_DEF;
					sys_hold = sys_sum / AVERAGE_SAMPLES_DEF;
					dia_sum = 0;
					sys_sum = 0;
					sample_cnt = 0;
					alarm_on = (dia_hold > dia_hi) || (dia_hold < dia_lo) ||
						(sys_hold > sys_hi) || (sys_hold < sys_lo);
				end
				// A finished pulse window is checked on the next sample
				if (rate_pending) begin
					rate_pending = 1'b0;
					alarm_on = (rate_hold > pulse_hi) || (rate_hold < pulse_lo);
				end
				buzz_cnt = (buzz_cnt + 1) % 256;
				if (buzz_cnt > BUZZER_DIVIDE_DEF * 10)
					buzz_cnt = BUZZER_DIVIDE_DEF + 1;
				if ((buzz_cnt % BUZZER_DIVIDE_DEF) == 0 && alarm_on)
					buzz_pin = !buzz_pin;
			end
			MODE_EDGE: edge_cnt = (edge_cnt + 1) % 256;
			MODE_TICK: begin
				tick_cnt++;
				if (tick_cnt >= TICKS_PER_SECOND_DEF) begin
					tick_cnt = 0;
					sec_cnt++;
				end
				if (sec_cnt >= WINDOW_SECONDS_DEF) begin
					sec_cnt = 0;
					rate_hold = (edge_cnt * BEATS_PER_EDGE) % 256;
					edge_cnt = 0;
					rate_pending = 1'b1;
				end
			end
			default: ;
			endcase
			want.alarm       = alarm_on;
			want.buzzer      = buzz_pin;
			want.temp_tenths = temp_hold[TEMP_W-1:0];
			want.dia_avg     = dia_hold[PRESS_W-1:0];
			want.sys_avg     = sys_hold[PRESS_W-1:0];
			want.pulse_rate  = rate_hold[RATE_W-1:0];
			expected_readings.push_back(want);
		endfunction

		function void report(string msg);
			if (mismatches < 10)
				$display("%0t ns: mismatch: %s", $time, msg);
			mismatches++;
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_readings.size() == 0) begin
				report("result transferred with no prediction waiting");
				return;
			end
			want = expected_readings.pop_front();
			if (got.alarm !== want.alarm || got.buzzer !== want.buzzer ||
					got.temp_tenths !== want.temp_tenths || got.dia_avg !== want.dia_avg ||
					got.sys_avg !== want.sys_avg || got.pulse_rate !== want.pulse_rate)
				report($sformatf({"expected/actual alarm %0b/%0b buzzer %0b/%0b ",
					"temp %0d/%0d dia %0d/%0d sys %0d/%0d rate %0d/%0d"},
					want.alarm, got.alarm, want.buzzer, got.buzzer,
					$signed(want.temp_tenths), $signed(got.temp_tenths),
					want.dia_avg, got.dia_avg, want.sys_avg, got.sys_avg,
					want.pulse_rate, got.pulse_rate));
		endfunction

		function int pending();
			return expected_readings.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Signals
	// ------------------------------------------------------------------------
	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [MODE_W-1:0]        mode;
	logic                     temp_valid;
	logic signed [TEMP_W-1:0] temp_raw;
	logic [RAW_W-1:0]         diastolic_raw;
	logic [RAW_W-1:0]         systolic_raw;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     alarm;
	logic                     buzzer_level;
	logic signed [TEMP_W-1:0] temperature_tenths;
	logic [PRESS_W-1:0]       diastolic_avg;
	logic [PRESS_W-1:0]       systolic_avg;
	logic [RATE_W-1:0]        pulse_rate;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_data;

	vital_check_board board;
	// Set during one long segment: neither side idles or stalls
	bit quiet = 1'b0;

	vital_sign_alarm_monitor_core i_dut (.*);

	// 8 ns clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop well past the slowest legal run
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Result side: stall with a chance of 13 in a hundred, except in the quiet stretch
	always @(posedge clk)
		out_stall <= !quiet && ($urandom_range(99) < 13);

	// Check every result transfer against the oldest prediction
	always @(posedge clk) begin : watch_results
		result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.alarm       = alarm;
			got.buzzer      = buzzer_level;
			got.temp_tenths = temperature_tenths;
			got.dia_avg     = diastolic_avg;
			got.sys_avg     = systolic_avg;
			got.pulse_rate  = pulse_rate;
			board.check_result(got);
		end
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------
	function automatic reading_t make_reading(logic [MODE_W-1:0] m, bit tv, int t, int d, int s);
		reading_t r;
		r.mode       = m;
		r.temp_valid = tv;
		r.temp_raw   = TEMP_W'(t);
		r.dia_raw    = RAW_W'(d);
		r.sys_raw    = RAW_W'(s);
		return r;
	endfunction

	// Present one item, hold it until the transfer, then note it.
	// Valid stays high afterwards so back-to-back items can follow without a gap.
	task automatic send_reading(input reading_t it);
		if (!quiet) begin
			while ($urandom_range(99) < 13) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid      <= 1'b1;
		mode          <= it.mode;
		temp_valid    <= it.temp_valid;
		temp_raw      <= it.temp_raw;
		diastolic_raw <= it.dia_raw;
		systolic_raw  <= it.sys_raw;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_item(it);
	endtask

	// Drop valid right after the last transfer and hold until all results are in
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// Write all eight limits; pressure and pulse writes carry junk above their width
	task automatic program_limits(input limits_t lim);
		cfg_idx_t idx;
		logic [CFG_DATA_W-1:0] data;
		idx = REG_TEMP_HIGH;
		repeat (idx.num()) begin
			data = CFG_DATA_W'($urandom);
			case (idx)
			REG_TEMP_HIGH:  data = lim.temp_high;
			REG_TEMP_LOW:   data = lim.temp_low;
			REG_DIA_HIGH:   data[PRESS_W-1:0] = lim.dia_high;
			REG_DIA_LOW:    data[PRESS_W-1:0] = lim.dia_low;
			REG_SYS_HIGH:   data[PRESS_W-1:0] = lim.sys_high;
			REG_SYS_LOW:    data[PRESS_W-1:0] = lim.sys_low;
			REG_PULSE_HIGH: data[RATE_W-1:0] = lim.pulse_high;
			REG_PULSE_LOW:  data[RATE_W-1:0] = lim.pulse_low;
			default: ;
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= data;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			board.set_limit(idx, data);
			idx = idx.next();
		end
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		reading_t it;
		limits_t lim;
		int t_pct, e_pct, u_pct, roll;

		board = new();
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		mode          <= MODE_SAMPLE;
		temp_valid    <= 1'b0;
		temp_raw      <= '0;
		diastolic_raw <= '0;
		systolic_raw  <= '0;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_TEMP_HIGH;
		cfg_data      <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening under the reset limits.
		// Temperature extremes, negative floor and a value just inside the high limit.
		send_reading(make_reading(MODE_SAMPLE, 1'b1, -2048, 0, 255));
		send_reading(make_reading(MODE_SAMPLE, 1'b1, 2047, 255, 0));
		send_reading(make_reading(MODE_SAMPLE, 1'b1, -1, 128, 127));
		send_reading(make_reading(MODE_SAMPLE, 1'b1, -15, 1, 254));
		send_reading(make_reading(MODE_SAMPLE, 1'b1, 595, 200, 55));
		// Stale temperature with no valid flag is ignored
		send_reading(make_reading(MODE_SAMPLE, 1'b0, 2047, 46, 71));
		// Edge, tick and spare mode with junk in the unused fields
		send_reading(make_reading(MODE_EDGE, 1'b1, 100, 255, 255));
		send_reading(make_reading(MODE_TICK, 1'b1, -2048, 255, 255));
		send_reading(make_reading(MODE_SPARE, 1'b1, 1000, 17, 99));
		// Eighth sample closes the first average
		send_reading(make_reading(MODE_SAMPLE, 1'b1, 584, 90, 160));
		send_reading(make_reading(MODE_SAMPLE, 1'b1, 596, 46, 71));
		// A full batch of in-range pressures clears the alarm
		repeat (8)
			send_reading(make_reading(MODE_SAMPLE, 1'b0, 0, 40, 60));
		send_reading(make_reading(MODE_EDGE, 1'b0, 0, 0, 0));
		send_reading(make_reading(MODE_SPARE, 1'b0, 0, 0, 0));
		wait_drained();

		// Random segments, each under its own limit set and item mix
		for (int seg = 0; seg < 7; seg++) begin
			case (seg)
			// only temperatures outside -550 to 1250 tenths alarm
			0: lim = '{12'sd1250, -12'sd550, 9'd500, 9'd0, 9'd500, 9'd0, 8'd255, 8'd0};
			// every check alarms
			1: lim = '{-12'sd550, 12'sd1250, 9'd0, 9'd500, 9'd0, 9'd500, 8'd0, 8'd255};
			// full register width
			2: lim = '{12'sd2047, 12'sh800, 9'd511, 9'd0, 9'd511, 9'd0, 8'd255, 8'd0};
			default: begin
				lim.temp_high  = TEMP_W'($urandom_range(1800) - 550);
				lim.temp_low   = TEMP_W'($urandom_range(1800) - 550);
				lim.dia_high   = PRESS_W'($urandom_range(500));
				lim.dia_low    = PRESS_W'($urandom_range(500));
				lim.sys_high   = PRESS_W'($urandom_range(500));
				lim.sys_low    = PRESS_W'($urandom_range(500));
				lim.pulse_high = RATE_W'($urandom_range(255));
				lim.pulse_low  = RATE_W'($urandom_range(255));
			end
			endcase
			program_limits(lim);
			quiet = (seg == 3);

			// Tick-heavy mixes are weighted up so pulse windows actually close
			case ($urandom_range(4))
			0, 1: begin t_pct = 90; e_pct = 3;  u_pct = 1; end
			2:    begin t_pct = 45; e_pct = 15; u_pct = 3; end
			3:    begin t_pct = 15; e_pct = 10; u_pct = 3; end
			default: begin t_pct = 20; e_pct = 65; u_pct = 2; end
			endcase

			repeat (250) begin
				roll = $urandom_range(99);
				it.temp_valid = 1'($urandom_range(1));
				it.temp_raw   = TEMP_W'($urandom);
				it.dia_raw    = RAW_W'($urandom);
				it.sys_raw    = RAW_W'($urandom);
				if (roll < t_pct)
					it.mode = MODE_TICK;
				else if (roll < t_pct + e_pct)
					it.mode = MODE_EDGE;
				else if (roll < t_pct + e_pct + u_pct)
					it.mode = MODE_SPARE;
				else
					it.mode = MODE_SAMPLE;
				send_reading(it);
				// Now and then hold off until the pipe is empty
				if ($urandom_range(99) == 0)
					wait_drained();
			end
			wait_drained();
		end
		quiet = 1'b0;

		// Give any stray result time to show up
		repeat (8) @(posedge clk);
		if (board.mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
